FILE: rtl/core/hsr_pkg.sv
`timescale 1ns / 1ps

package hsr_pkg;

  // fixed field widths of one item
  localparam int ADDR_W = 12;
  localparam int LEN_W  = 3;
  localparam int DATA_W = 32;
  localparam int LANES  = 4;

  // access kinds
  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // first byte of the lock window, four bytes per lock
  localparam logic [ADDR_W-1:0] LOCK_BASE = 12'h0a0;

  // longest access in bytes
  localparam logic [LEN_W-1:0] MAX_LEN = 3'd4;

  // controller to datapath
  typedef struct packed {
    logic clear;   // clearing pass, one row per cycle
    logic accept;  // take the item and launch the memory reads
    logic exec;    // update memories and load the result register
  } hsr_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;  // clearing pass is on its last row
  } hsr_sts_t;

endpackage

FILE: rtl/core/hsr_ctrl.sv
`timescale 1ns / 1ps

module hsr_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  input  hsr_pkg::hsr_sts_t sts,
  output hsr_pkg::hsr_cmd_t cmd
);
  import hsr_pkg::*;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_EXEC  = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_busy;

  // result register still holds an item the sink has not taken
  assign out_busy = out_valid_r & out_stall;

  // commands
  always_comb begin
    cmd        = '0;
    cmd.clear  = (state_r == ST_CLEAR);
    cmd.accept = (state_r == ST_IDLE) & in_valid;
    cmd.exec   = (state_r == ST_EXEC) & ~out_busy;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (sts.clr_last) state_nxt = ST_IDLE;
      ST_IDLE:  if (in_valid) state_nxt = ST_EXEC;
      ST_EXEC:  if (!out_busy) state_nxt = ST_IDLE;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  // output valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.exec) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

FILE: rtl/core/hsr_dp.sv
`timescale 1ns / 1ps

module hsr_dp #(
  parameter int LOCK_COUNT   = 128,
  parameter int REGION_BYTES = 4096
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  hsr_pkg::hsr_cmd_t          cmd,
  output hsr_pkg::hsr_sts_t          sts,
  input  logic                       in_operation,
  input  logic [hsr_pkg::ADDR_W-1:0] in_byte_address,
  input  logic [hsr_pkg::LEN_W-1:0]  in_access_bytes,
  input  logic [hsr_pkg::DATA_W-1:0] in_write_data,
  output logic [hsr_pkg::DATA_W-1:0] out_read_data
);
  import hsr_pkg::*;

  localparam int ROWS    = (REGION_BYTES + LANES - 1) / LANES;
  localparam int ROW_W   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int SLOT_W  = (LOCK_COUNT > 1) ? $clog2(LOCK_COUNT) : 1;
  localparam int CLR_LEN = (ROWS > LOCK_COUNT) ? ROWS : LOCK_COUNT;
  localparam int CLR_W   = (CLR_LEN > 1) ? $clog2(CLR_LEN) : 1;

  // clearing pass counter
  logic [CLR_W-1:0] clr_cnt_r, clr_cnt_nxt;

  assign clr_cnt_nxt  = cmd.clear ? clr_cnt_r + 1'b1 : clr_cnt_r;
  assign sts.clr_last = (clr_cnt_r == CLR_W'(CLR_LEN - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else begin
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  // item decode: length clamp and lock window match
  logic [LEN_W-1:0]  len_cl;
  logic [ADDR_W-1:0] lock_off;
  logic              in_is_lock;
  logic [SLOT_W-1:0] in_slot;

  always_comb begin
    len_cl     = (in_access_bytes > MAX_LEN) ? MAX_LEN : in_access_bytes;
    lock_off   = in_byte_address - LOCK_BASE;
    in_is_lock = (len_cl == MAX_LEN) && (in_byte_address >= LOCK_BASE) &&
                 (lock_off[1:0] == 2'b00) &&
                 (32'(lock_off) < 32'(LOCK_COUNT * 4));
    in_slot    = SLOT_W'(lock_off[ADDR_W-1:2]);
  end

  // per-lane byte placement: lane b holds byte index idx of the item
  logic [1:0]        in_idx  [LANES];
  logic [ADDR_W:0]   in_sum  [LANES];
  logic [ROW_W-1:0]  in_row  [LANES];
  logic              in_ok   [LANES];
  logic [7:0]        in_wl   [LANES];

  always_comb begin
    for (int b = 0; b < LANES; b++) begin
      in_idx[b] = 2'(b) - in_byte_address[1:0];
      in_sum[b] = {1'b0, in_byte_address} + (ADDR_W + 1)'(in_idx[b]);
      in_row[b] = ROW_W'(in_sum[b][ADDR_W:2]);
      in_ok[b]  = ({1'b0, in_idx[b]} < len_cl) &&
                  (32'(in_sum[b]) < 32'(REGION_BYTES));
      in_wl[b]  = in_write_data[8*in_idx[b] +: 8];
    end
  end

  // item registers
  logic              op_write_r;
  logic              is_lock_r;
  logic [SLOT_W-1:0] slot_r;
  logic              wnz_r;
  logic [1:0]        idx_r  [LANES];
  logic [ROW_W-1:0]  row_r  [LANES];
  logic              ok_r   [LANES];
  logic [7:0]        wl_r   [LANES];

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_write_r <= (in_operation == OP_WRITE);
      is_lock_r  <= in_is_lock;
      slot_r     <= in_slot;
      wnz_r      <= (in_write_data != '0);
      for (int b = 0; b < LANES; b++) begin
        idx_r[b] <= in_idx[b];
        row_r[b] <= in_row[b];
        ok_r[b]  <= in_ok[b];
        wl_r[b]  <= in_wl[b];
      end
    end
  end

  // lock bit memory
  logic              lk_mem [LOCK_COUNT];
  logic              lk_rd_r;
  logic              lk_we;
  logic              lk_wd;
  logic [SLOT_W-1:0] lk_wa;
  logic              acquire;

  assign acquire = ~op_write_r & is_lock_r & ~lk_rd_r;

  always_comb begin
    lk_we = 1'b0;
    lk_wd = 1'b0;
    lk_wa = slot_r;
    if (cmd.clear) begin
      lk_we = (32'(clr_cnt_r) < 32'(LOCK_COUNT));
      lk_wa = SLOT_W'(clr_cnt_r);
    end else if (cmd.exec) begin
      lk_we = is_lock_r & (op_write_r | ~lk_rd_r);
      lk_wd = op_write_r ? wnz_r : 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (lk_we) begin
      lk_mem[lk_wa] <= lk_wd;
    end
    if (cmd.accept) begin
      lk_rd_r <= lk_mem[in_slot];
    end
  end

  // byte lane memories, one read and one write port each
  logic [7:0] rd_r [LANES];

  for (genvar gb = 0; gb < LANES; gb++) begin : g_lane
    logic [7:0]       mem [ROWS];
    logic             we;
    logic [7:0]       wd;
    logic [ROW_W-1:0] wa;

    always_comb begin
      we = 1'b0;
      wd = 8'h00;
      wa = row_r[gb];
      if (cmd.clear) begin
        we = (32'(clr_cnt_r) < 32'(ROWS));
        wa = ROW_W'(clr_cnt_r);
      end else if (cmd.exec) begin
        we = ok_r[gb] & (op_write_r | acquire);
        // a taken lock stores the word 1
        wd = op_write_r ? wl_r[gb] : ((idx_r[gb] == 2'd0) ? 8'h01 : 8'h00);
      end
    end

    always_ff @(posedge clk) begin
      if (we) begin
        mem[wa] <= wd;
      end
      if (cmd.accept) begin
        rd_r[gb] <= mem[in_row[gb]];
      end
    end
  end

  // result assembly
  logic [DATA_W-1:0] res;
  logic [DATA_W-1:0] out_read_data_r;

  always_comb begin
    res = '0;
    if (op_write_r) begin
      res = '0;
    end else if (is_lock_r) begin
      res = DATA_W'(lk_rd_r);
    end else begin
      for (int b = 0; b < LANES; b++) begin
        if (ok_r[b]) begin
          res = res | (DATA_W'(rd_r[b]) << {idx_r[b], 3'b000});
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      out_read_data_r <= res;
    end
  end

  assign out_read_data = out_read_data_r;

endmodule

FILE: rtl/core/hardware_spinlock_registers.sv
`timescale 1ns / 1ps

// Hardware spinlock register block. Each item is a 1 to 4 byte read or write into a
// little-endian byte register region; an aligned 4-byte access in the lock window at
// 0xa0 (four bytes per lock) acts on a lock: a read of a free lock takes it and returns
// 0, a read of a held lock returns 1, a write sets the lock to (data != 0). Every item
// gives one result, zero for writes. The accept step reads the four byte-lane memories
// and the lock memory into registers; the EXEC state then does the write-back and
// loads the result register, and it waits while the result register is stalled.
// After reset a clearing pass over max(ceil(REGION_BYTES/4), LOCK_COUNT) rows (1024 at
// the defaults) zeroes both memories while in_stall is held high.
module hardware_spinlock_registers #(
  parameter int LOCK_COUNT   = 128,
  parameter int REGION_BYTES = 4096
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_operation,
  input  logic [hsr_pkg::ADDR_W-1:0] in_byte_address,
  input  logic [hsr_pkg::LEN_W-1:0]  in_access_bytes,
  input  logic [hsr_pkg::DATA_W-1:0] in_write_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [hsr_pkg::DATA_W-1:0] out_read_data
);
  import hsr_pkg::*;

  hsr_cmd_t cmd;
  hsr_sts_t sts;

  // sequencing
  hsr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // memories and result path
  hsr_dp #(
    .LOCK_COUNT   (LOCK_COUNT),
    .REGION_BYTES (REGION_BYTES)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_operation    (in_operation),
    .in_byte_address (in_byte_address),
    .in_access_bytes (in_access_bytes),
    .in_write_data   (in_write_data),
    .out_read_data   (out_read_data)
  );

  // one item in flight: an accept is followed by a stalled input
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |=> in_stall)
    else $error("item accepted while previous item in flight");

  // write-back never overlaps a clearing pass or a new accept
  a_exec_alone: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |-> (!cmd.accept && !cmd.clear))
    else $error("write-back overlaps another command");

  // a new result shows only after a write-back
  a_out_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(cmd.exec))
    else $error("result valid without write-back");

  // no item is taken during the clearing pass
  a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear |-> in_stall)
    else $error("input open during clearing pass");

endmodule
